FILE: hw/rtl/srtn_preemptive_scheduler_assert.svh
// assertion macros for the srtn scheduler
// no dependencies; included by the top level
`ifndef SRTN_PREEMPTIVE_SCHEDULER_ASSERT_SVH
`define SRTN_PREEMPTIVE_SCHEDULER_ASSERT_SVH

// condition holds in the same cycle
`define SRTN_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("srtn scheduler check failed");

// condition holds in the next cycle
`define SRTN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("srtn scheduler check failed");

`endif

FILE: hw/rtl/srtn_pkg.sv
// shared types and constants for the srtn scheduler
// no dependencies; used by srtn_alu and the top level
package srtn_pkg;

    localparam int CLK_W = 32;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT,
        ST_PLACE,
        ST_POP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic lt;
        logic zero;
    } alu_flags_t;

endpackage

FILE: hw/rtl/srtn_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module srtn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/srtn_alu.sv
// shared subtract and compare unit of the srtn scheduler
// depends on srtn_pkg
module srtn_alu #(
    parameter int W = 16
) (
    input  logic                  [W-1:0] a,
    input  logic                  [W-1:0] b,
    output logic                  [W-1:0] diff,
    output srtn_pkg::alu_flags_t          flags
);

    logic [W:0] full_diff;

    assign full_diff  = {1'b0, a} - {1'b0, b};
    assign diff       = full_diff[W-1:0];
    assign flags.lt   = full_diff[W];
    assign flags.zero = (full_diff[W-1:0] == '0);

endmodule

FILE: hw/rtl/srtn_preemptive_scheduler.sv
// srtn preemptive scheduler top level: sequencer, run state, queue pointers
// depends on srtn_pkg, srtn_ram, srtn_alu and srtn_preemptive_scheduler_assert.svh
//
// channel  dir  tdata (low bit up)                                       tuser
// s_       in   task_id, duration                                        func
// m_       out  running_id, cpu_idle, finished, finished_id,             -
//               finish_time, queue_full
//
// an item runs exec and emit; a tick that pulls the queue head from the ram also runs pop
// sorted insert: exec, shift over up to QUEUE_DEPTH - 1 entries, place if all passed, emit
// the queue ram walks one entry per cycle through the shared subtract/compare unit
// a result waits in the output register; a held result stalls only the next emit
// reset is synchronous; the queue ram needs no clearing
`include "srtn_preemptive_scheduler_assert.svh"

module srtn_preemptive_scheduler #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int TIME_BITS   = 16,
    localparam int S_DATA_W   = ((ID_BITS + TIME_BITS + 7) / 8) * 8,
    localparam int M_FIELD_W  = 2 * ID_BITS + 3 + srtn_pkg::CLK_W,
    localparam int M_DATA_W   = ((M_FIELD_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // task_id, duration
    input  logic                s_tuser,   // func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // running_id, cpu_idle, finished,
                                           // finished_id, finish_time, queue_full
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_BITS + TIME_BITS;
    localparam int CLK_W   = srtn_pkg::CLK_W;

    function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == '0) begin
            r = IDX_W'(QUEUE_DEPTH - 1);
        end else begin
            r = p - IDX_W'(1);
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == IDX_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + IDX_W'(1);
        end
        return r;
    endfunction

    srtn_pkg::state_t state_reg, state_next;

    logic                 func_reg, func_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [TIME_BITS-1:0] dur_reg, dur_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ID_BITS-1:0]   run_id_reg, run_id_next;
    logic [TIME_BITS-1:0] run_rem_reg, run_rem_next;
    logic                 run_valid_reg, run_valid_next;
    logic [CLK_W-1:0]     clock_reg, clock_next;
    logic [IDX_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic                 fin_reg, fin_next;
    logic [ID_BITS-1:0]   fin_id_reg, fin_id_next;
    logic [CLK_W-1:0]     fin_time_reg, fin_time_next;
    logic                 full_reg, full_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [ID_BITS-1:0]   rd_id;
    logic [TIME_BITS-1:0] rd_rem;

    logic [TIME_BITS-1:0] alu_a, alu_b, alu_diff;
    srtn_pkg::alu_flags_t alu_flags;

    logic [CNT_W:0]       tail_sum;
    logic [IDX_W-1:0]     tail;
    logic                 q_full, q_empty, rem_le1, out_free, s_accept;
    logic [M_FIELD_W-1:0] out_fields;

    srtn_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srtn_alu #(
        .W (TIME_BITS)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .diff  (alu_diff),
        .flags (alu_flags)
    );

    assign rd_id  = ram_rdata[ENTRY_W-1:TIME_BITS];
    assign rd_rem = ram_rdata[TIME_BITS-1:0];

    assign tail_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign tail     = (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                      ? IDX_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH))
                      : IDX_W'(tail_sum);

    assign q_full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty  = (count_reg == '0);
    assign rem_le1  = alu_flags.lt | alu_flags.zero;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == srtn_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // operand select for the shared unit
    always_comb begin
        alu_a = dur_reg;
        alu_b = run_rem_reg;
        case (state_reg)
            srtn_pkg::ST_EXEC: begin
                if (func_reg == srtn_pkg::FUNC_TICK) begin
                    alu_a = run_rem_reg;
                    alu_b = TIME_BITS'(1);
                end
            end
            srtn_pkg::ST_SHIFT: begin
                alu_b = rd_rem;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srtn_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = srtn_pkg::ST_EXEC;
                end
            end
            srtn_pkg::ST_EXEC: begin
                state_next = srtn_pkg::ST_EMIT;
                if (func_reg == srtn_pkg::FUNC_ARRIVE) begin
                    if (run_valid_reg && !q_full && !alu_flags.lt && !q_empty) begin
                        state_next = srtn_pkg::ST_SHIFT;
                    end
                end else if (run_valid_reg && rem_le1 && !q_empty) begin
                    state_next = srtn_pkg::ST_POP;
                end
            end
            srtn_pkg::ST_SHIFT: begin
                if (!alu_flags.lt) begin
                    state_next = srtn_pkg::ST_EMIT;
                end else if (k_reg == CNT_W'(1)) begin
                    state_next = srtn_pkg::ST_PLACE;
                end
            end
            srtn_pkg::ST_PLACE: begin
                state_next = srtn_pkg::ST_EMIT;
            end
            srtn_pkg::ST_POP: begin
                state_next = srtn_pkg::ST_EMIT;
            end
            srtn_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = srtn_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = srtn_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        func_next      = func_reg;
        id_next        = id_reg;
        dur_next       = dur_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        run_id_next    = run_id_reg;
        run_rem_next   = run_rem_reg;
        run_valid_next = run_valid_reg;
        clock_next     = clock_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        k_next         = k_reg;
        fin_next       = fin_reg;
        fin_id_next    = fin_id_reg;
        fin_time_next  = fin_time_reg;
        full_next      = full_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_ptr_reg;
        ram_wdata      = {id_reg, dur_reg};
        ram_raddr      = head_reg;
        out_fields     = {full_reg, fin_time_reg, fin_id_reg, fin_reg, !run_valid_reg,
                          (run_valid_reg ? run_id_reg : ID_BITS'(0))};

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            srtn_pkg::ST_IDLE: begin
                if (s_accept) begin
                    func_next     = s_tuser;
                    id_next       = s_tdata[ID_BITS-1:0];
                    dur_next      = s_tdata[ENTRY_W-1:ID_BITS];
                    fin_next      = 1'b0;
                    fin_id_next   = '0;
                    fin_time_next = '0;
                    full_next     = 1'b0;
                end
            end
            srtn_pkg::ST_EXEC: begin
                if (func_reg == srtn_pkg::FUNC_ARRIVE) begin
                    if (!run_valid_reg) begin
                        run_id_next    = id_reg;
                        run_rem_next   = dur_reg;
                        run_valid_next = 1'b1;
                    end else if (q_full) begin
                        full_next = 1'b1;
                    end else if (alu_flags.lt) begin
                        // preempt: running task goes to the queue head
                        ram_we       = 1'b1;
                        ram_waddr    = ptr_dec(head_reg);
                        ram_wdata    = {run_id_reg, run_rem_reg};
                        head_next    = ptr_dec(head_reg);
                        count_next   = count_reg + CNT_W'(1);
                        run_id_next  = id_reg;
                        run_rem_next = dur_reg;
                    end else if (q_empty) begin
                        ram_we     = 1'b1;
                        ram_waddr  = tail;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        wr_ptr_next = tail;
                        rd_ptr_next = ptr_dec(tail);
                        ram_raddr   = ptr_dec(tail);
                        k_next      = count_reg;
                    end
                end else begin
                    clock_next = clock_reg + CLK_W'(1);
                    if (run_valid_reg) begin
                        if (rem_le1) begin
                            fin_next      = 1'b1;
                            fin_id_next   = run_id_reg;
                            fin_time_next = clock_reg + CLK_W'(1);
                            if (q_empty) begin
                                run_valid_next = 1'b0;
                                run_id_next    = '0;
                                run_rem_next   = '0;
                            end
                        end else begin
                            run_rem_next = alu_diff;
                        end
                    end
                end
            end
            srtn_pkg::ST_SHIFT: begin
                ram_we = 1'b1;
                if (!alu_flags.lt) begin
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    ram_wdata   = ram_rdata;
                    wr_ptr_next = rd_ptr_reg;
                    rd_ptr_next = ptr_dec(rd_ptr_reg);
                    ram_raddr   = ptr_dec(rd_ptr_reg);
                    k_next      = k_reg - CNT_W'(1);
                end
            end
            srtn_pkg::ST_PLACE: begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            srtn_pkg::ST_POP: begin
                run_id_next  = rd_id;
                run_rem_next = rd_rem;
                head_next    = ptr_inc(head_reg);
                count_next   = count_reg - CNT_W'(1);
            end
            srtn_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'(out_fields);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= srtn_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            run_id_reg    <= '0;
            run_rem_reg   <= '0;
            run_valid_reg <= 1'b0;
            clock_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            run_id_reg    <= run_id_next;
            run_rem_reg   <= run_rem_next;
            run_valid_reg <= run_valid_next;
            clock_reg     <= clock_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        id_reg       <= id_next;
        dur_reg      <= dur_next;
        wr_ptr_reg   <= wr_ptr_next;
        rd_ptr_reg   <= rd_ptr_next;
        k_reg        <= k_next;
        fin_reg      <= fin_next;
        fin_id_reg   <= fin_id_next;
        fin_time_reg <= fin_time_next;
        full_reg     <= full_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SRTN_ASSERT_SAME(a_queue_needs_runner, aclk, aresetn, count_reg != '0, run_valid_reg)
    `SRTN_ASSERT_SAME(a_write_has_room, aclk, aresetn, ram_we, count_reg < CNT_W'(QUEUE_DEPTH))
    `SRTN_ASSERT_SAME(a_shift_in_range, aclk, aresetn, state_reg == srtn_pkg::ST_SHIFT, (k_reg != '0) && (k_reg <= count_reg))
    `SRTN_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_accept, !s_tready)

endmodule
